FILE: design/manchester_edge_timing_decoder_defines.svh
// ---------------------------------------------------------------------------
// Manchester edge-timing decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ---------------------------------------------------------------------------
`ifndef MANCHESTER_EDGE_TIMING_DECODER_DEFINES_SVH
`define MANCHESTER_EDGE_TIMING_DECODER_DEFINES_SVH

// General form with an explicit clock and active-low reset.
`define MET_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Form on the block clock and reset.
`define MET_ASSERT(lbl, prop, msg) `MET_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/met_pkg.sv
// ---------------------------------------------------------------------------
// Manchester edge-timing decoder package
// Types and fixed constants shared by the decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned PH_CODE_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_MIN     = 3'd0,
    CFG_HALF_MAX     = 3'd1,
    CFG_FULL_MIN     = 3'd2,
    CFG_FULL_MAX     = 3'd3,
    CFG_IDLE_TIMEOUT = 3'd4
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] HALF_MIN_RST     = 16'd400;
  localparam logic [CFG_W-1:0] HALF_MAX_RST     = 16'd600;
  localparam logic [CFG_W-1:0] FULL_MIN_RST     = 16'd800;
  localparam logic [CFG_W-1:0] FULL_MAX_RST     = 16'd1200;
  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd2000;

  typedef enum logic {
    KIND_POLL = 1'b0,
    KIND_EDGE = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    PH_LEAD_RISE = 4'b0001,
    PH_LEAD_FALL = 4'b0010,
    PH_MID_RISE  = 4'b0100,
    PH_MID_FALL  = 4'b1000
  } phase_e;

  localparam logic [PH_CODE_W-1:0] PH_CODE_LEAD_RISE = 2'd0;
  localparam logic [PH_CODE_W-1:0] PH_CODE_LEAD_FALL = 2'd1;
  localparam logic [PH_CODE_W-1:0] PH_CODE_MID_RISE  = 2'd2;
  localparam logic [PH_CODE_W-1:0] PH_CODE_MID_FALL  = 2'd3;

  typedef enum logic [1:0] {
    W_INVALID = 2'd0,
    W_HALF    = 2'd1,
    W_FULL    = 2'd2
  } width_e;

  typedef struct packed {
    logic               is_edge;
    logic               rising;
    logic [FIELD_W-1:0] now;
    logic [FIELD_W-1:0] edge_t;
  } event_t;

endpackage

`default_nettype wire

FILE: design/met_if.sv
// ---------------------------------------------------------------------------
// Manchester edge-timing decoder channels
// Valid/ready interfaces for the input and result channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface met_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] current_time;
  logic        edge_rising;
  logic [15:0] edge_time;

  modport source (output valid, kind, current_time, edge_rising, edge_time, input ready);
  modport sink (input valid, kind, current_time, edge_rising, edge_time, output ready);
endinterface

interface met_out_if;
  logic        valid;
  logic        ready;
  logic        word_ready;
  logic [15:0] received_word;
  logic [1:0]  decoder_phase;

  modport source (output valid, word_ready, received_word, decoder_phase, input ready);
  modport sink (input valid, word_ready, received_word, decoder_phase, output ready);
endinterface

`default_nettype wire

FILE: design/met_front.sv
// ---------------------------------------------------------------------------
// Manchester edge-timing decoder front end
// Accepts input beats, sorts them into time checks and edge events and
// holds them in a two-entry queue ahead of the decoder core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module met_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  met_in_if.sink              in_i,
  output met_pkg::event_t     ev_o,
  output logic                ev_valid_o,
  input  wire logic           ev_pop_i
);
  import met_pkg::*;

  event_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  event_t     ev_new;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = ev_pop_i && (cnt_q != 2'd0);

  always_comb begin
    ev_new.is_edge = (kind_e'(in_i.kind) == KIND_EDGE);
    ev_new.rising  = in_i.edge_rising;
    ev_new.now     = in_i.current_time;
    ev_new.edge_t  = in_i.edge_time;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ev_new;
    end
  end

  assign ev_o       = mem_q[rd_ptr_q];
  assign ev_valid_o = (cnt_q != 2'd0);

endmodule

`default_nettype wire

FILE: design/met_back.sv
// ---------------------------------------------------------------------------
// Manchester edge-timing decoder core
// Holds the timing windows and decoder state, times each event against the
// idle timeout and the last marks, and registers one result per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module met_back #(
  parameter int unsigned WORD_BITS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [met_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [met_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire met_pkg::event_t               ev_i,
  input  wire logic                          ev_valid_i,
  output logic                               ev_pop_o,
  met_out_if.source                          out_o
);
  import met_pkg::*;

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int unsigned BW = $clog2(WORD_BITS + 1);

  function automatic width_e classify(input logic [CW-1:0]    w,
                                      input logic [CFG_W-1:0] hmin,
                                      input logic [CFG_W-1:0] hmax,
                                      input logic [CFG_W-1:0] fmin,
                                      input logic [CFG_W-1:0] fmax);
    width_e r;
    r = W_INVALID;
    if (w >= CW'(hmin) && w <= CW'(hmax)) begin
      r = W_HALF;
    end else if (w >= CW'(fmin) && w <= CW'(fmax)) begin
      r = W_FULL;
    end
    return r;
  endfunction

  logic [CFG_W-1:0]     half_min_q, half_max_q, full_min_q, full_max_q, idle_timeout_q;

  phase_e               phase_q, phase_d, phase_chk;
  logic [TW-1:0]        last_edge_q, last_edge_d;
  logic [TW-1:0]        lead_rise_q, lead_rise_d;
  logic [TW-1:0]        mid_mark_q, mid_mark_d;
  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic [BW-1:0]        bits_left_q, bits_left_d;
  logic [WORD_BITS-1:0] held_q, held_d;

  logic                 out_valid_q;
  logic                 out_word_ready_q;
  logic [FIELD_W-1:0]   out_word_q;
  logic [PH_CODE_W-1:0] out_phase_q;

  logic                 pop;
  logic                 ready_d;
  logic [TW-1:0]        now_t, edge_t;
  logic [TW-1:0]        idle_diff, lead_diff, mid_diff;
  logic                 timed_out;
  width_e               lead_w, mid_w;
  logic [WORD_BITS-1:0] shift_in;
  logic [PH_CODE_W-1:0] phase_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_min_q     <= HALF_MIN_RST;
      half_max_q     <= HALF_MAX_RST;
      full_min_q     <= FULL_MIN_RST;
      full_max_q     <= FULL_MAX_RST;
      idle_timeout_q <= IDLE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_MIN:     half_min_q     <= cfg_data_i;
        CFG_HALF_MAX:     half_max_q     <= cfg_data_i;
        CFG_FULL_MIN:     full_min_q     <= cfg_data_i;
        CFG_FULL_MAX:     full_max_q     <= cfg_data_i;
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign pop      = ev_valid_i && (!out_valid_q || out_o.ready);
  assign ev_pop_o = pop;

  assign now_t     = TW'(ev_i.now);
  assign edge_t    = TW'(ev_i.edge_t);
  assign idle_diff = now_t - last_edge_q;
  assign lead_diff = edge_t - lead_rise_q;
  assign mid_diff  = edge_t - mid_mark_q;
  assign timed_out = CW'(idle_diff) > CW'(idle_timeout_q);
  assign lead_w    = classify(CW'(lead_diff), half_min_q, half_max_q, full_min_q, full_max_q);
  assign mid_w     = classify(CW'(mid_diff), half_min_q, half_max_q, full_min_q, full_max_q);
  assign shift_in  = WORD_BITS'({shift_q, ev_i.rising});
  assign phase_chk = timed_out ? PH_LEAD_RISE : phase_q;

  always_comb begin
    phase_d     = phase_chk;
    last_edge_d = last_edge_q;
    lead_rise_d = lead_rise_q;
    mid_mark_d  = mid_mark_q;
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    held_d      = held_q;
    ready_d     = 1'b0;
    if (ev_i.is_edge) begin
      last_edge_d = edge_t;
      unique case (phase_chk)
        PH_LEAD_RISE: begin
          if (ev_i.rising) begin
            lead_rise_d = edge_t;
            phase_d     = PH_LEAD_FALL;
          end
        end
        PH_LEAD_FALL: begin
          if (!ev_i.rising && lead_w == W_FULL) begin
            shift_d     = '0;
            mid_mark_d  = edge_t;
            bits_left_d = BW'(WORD_BITS);
            phase_d     = PH_MID_RISE;
          end else begin
            phase_d = PH_LEAD_RISE;
          end
        end
        PH_MID_RISE, PH_MID_FALL: begin
          if (ev_i.rising != (phase_chk == PH_MID_RISE)) begin
            phase_d = PH_LEAD_RISE;
          end else if (mid_w == W_HALF) begin
            phase_d = ev_i.rising ? PH_MID_FALL : PH_MID_RISE;
          end else if (mid_w != W_FULL) begin
            phase_d = PH_LEAD_RISE;
          end else if (bits_left_q <= BW'(1)) begin
            shift_d     = shift_in;
            bits_left_d = '0;
            held_d      = shift_in;
            phase_d     = PH_LEAD_RISE;
            ready_d     = 1'b1;
          end else begin
            shift_d     = shift_in;
            bits_left_d = bits_left_q - BW'(1);
            mid_mark_d  = edge_t;
            phase_d     = ev_i.rising ? PH_MID_FALL : PH_MID_RISE;
          end
        end
        default: begin
          phase_d = PH_LEAD_RISE;
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_d)
      PH_LEAD_RISE: phase_code = PH_CODE_LEAD_RISE;
      PH_LEAD_FALL: phase_code = PH_CODE_LEAD_FALL;
      PH_MID_RISE:  phase_code = PH_CODE_MID_RISE;
      PH_MID_FALL:  phase_code = PH_CODE_MID_FALL;
      default:      phase_code = PH_CODE_LEAD_RISE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD_RISE;
      last_edge_q <= '0;
      lead_rise_q <= '0;
      mid_mark_q  <= '0;
      shift_q     <= '0;
      bits_left_q <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q     <= phase_d;
        last_edge_q <= last_edge_d;
        lead_rise_q <= lead_rise_d;
        mid_mark_q  <= mid_mark_d;
        shift_q     <= shift_d;
        bits_left_q <= bits_left_d;
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_word_ready_q <= ready_d;
      out_word_q       <= FIELD_W'(held_d);
      out_phase_q      <= phase_code;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.word_ready    = out_word_ready_q;
  assign out_o.received_word = out_word_q;
  assign out_o.decoder_phase = out_phase_q;

endmodule

`default_nettype wire

FILE: design/manchester_edge_timing_decoder.sv
// Each beat is queued in the front end, then registered as a result when the core pops it.
// Throughput: one beat per cycle while the result register is empty or being read.
// A two-entry queue lets input beats be taken while a result waits on the output.
// Reset: asynchronous, active low; control state and timing windows return to
// reset values at once, with no clearing pass; queue and output data are not reset.
// ---------------------------------------------------------------------------
// Manchester edge-timing decoder
// Decodes a Manchester line from timestamped edges into received words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "manchester_edge_timing_decoder_defines.svh"

module manchester_edge_timing_decoder #(
  parameter int unsigned WORD_BITS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [met_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [met_pkg::CFG_W-1:0]     cfg_data_i,
  met_in_if.sink                             in_i,
  met_out_if.source                          out_o
);
  import met_pkg::*;

  event_t ev;
  logic   ev_valid;
  logic   ev_pop;

  met_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .ev_o       (ev),
    .ev_valid_o (ev_valid),
    .ev_pop_i   (ev_pop)
  );

  met_back #(
    .WORD_BITS (WORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ev_i       (ev),
    .ev_valid_i (ev_valid),
    .ev_pop_o   (ev_pop),
    .out_o      (out_o)
  );

  `MET_ASSERT(a_word_ends_frame, out_o.valid && out_o.word_ready |-> out_o.decoder_phase == PH_CODE_LEAD_RISE, "word beat not in lead-in phase")
  `MET_ASSERT(a_full_queue_has_result, !in_i.ready |-> out_o.valid, "input stalled without a pending result")

endmodule

`default_nettype wire
